// File: sv/itp_pkg.sv
// ----------------------------------------------------------------------------
// itp_pkg: shared types and constants for the ISO 8601 time parser
// Character codes, parse phases, field widths and calendar constants.
// ----------------------------------------------------------------------------
package itp_pkg;

    localparam int NUM_BITS      = 32;
    localparam int IN_TDATA_W    = 8;
    localparam int TIME_W        = 49;
    localparam int LIMIT_W       = 48;
    localparam int OUT_TDATA_W   = ((TIME_W + 7) / 8) * 8;
    localparam int OUT_TUSER_W   = 2;
    localparam int YEAR_W        = 14;
    localparam int MONTH_W       = 7;
    localparam int POS_W         = 4;
    localparam int UNITS_W       = 4;
    localparam int DATE_FIELD_W  = 7;

    localparam int YADJ_W        = 15;
    localparam int RECIP_W       = 16;
    localparam int ERA_PROD_W    = YADJ_W + RECIP_W;
    localparam int ERA_SHIFT     = 24;
    localparam int ERA_W         = ERA_PROD_W - ERA_SHIFT;
    localparam int MI_W          = 4;
    localparam int YOE_W         = 9;
    localparam int MOFF_W        = 9;
    localparam int DOE_W         = 18;
    localparam int ERA_DAYS_W    = 24;
    localparam int DAYS_W        = 25;
    localparam int DMUL_W        = (NUM_BITS + 1 > DAYS_W) ? NUM_BITS + 1 : DAYS_W;
    localparam int SUM_W         = (NUM_BITS + 19 > 50) ? NUM_BITS + 19 : 50;

    localparam int ERA_RECIP         = 41944;
    localparam int YEARS_PER_ERA     = 400;
    localparam int DAYS_PER_ERA      = 146097;
    localparam int DAYS_PER_YEAR     = 365;
    localparam int MONTHS_PER_YEAR   = 12;
    localparam int EPOCH_DAY_OFFSET  = 865566;
    localparam int SEC_PER_DAY       = 86400;
    localparam int SEC_PER_HOUR      = 3600;
    localparam int SEC_PER_MIN       = 60;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_Z     = 8'h5A;

    localparam logic [UNITS_W-1:0] UNIT_D = 4'b1000;
    localparam logic [UNITS_W-1:0] UNIT_H = 4'b0100;
    localparam logic [UNITS_W-1:0] UNIT_M = 4'b0010;
    localparam logic [UNITS_W-1:0] UNIT_S = 4'b0001;
    localparam logic [UNITS_W-1:0] MASK_D = 4'b1111;
    localparam logic [UNITS_W-1:0] MASK_H = 4'b0111;
    localparam logic [UNITS_W-1:0] MASK_M = 4'b0011;
    localparam logic [UNITS_W-1:0] MASK_S = 4'b0001;

    typedef enum logic [4:0] {
        PH_START,
        PH_DUR,
        PH_YEAR,
        PH_AFTER_YEAR,
        PH_MONTH,
        PH_MONTH_X,
        PH_AFTER_MONTH,
        PH_AFTER_MONTH_X,
        PH_DAY,
        PH_AFTER_DATE,
        PH_HOUR,
        PH_AFTER_HOUR,
        PH_MIN,
        PH_AFTER_MIN,
        PH_AFTER_COLON,
        PH_SEC,
        PH_AFTER_SEC,
        PH_ZONE,
        PH_DONE_DUR,
        PH_DONE_DATE
    } phase_t;

    // kind: 0 duration, 1 point in time
    typedef struct packed {
        logic                kind;
        logic                failed;
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [NUM_BITS-1:0] day;
        logic [NUM_BITS-1:0] hour;
        logic [NUM_BITS-1:0] minute;
        logic [NUM_BITS-1:0] second;
    } fields_t;

    // days from March 1 to the start of month index mp (March = 0)
    function automatic logic [MOFF_W-1:0] month_offset(input logic [MI_W-1:0] mp);
        logic [MOFF_W-1:0] r;
        case (mp)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd92;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd184;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd245;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd306;
            4'd11:   r = 9'd337;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

// File: sv/itp_parser.sv
// ----------------------------------------------------------------------------
// itp_parser: character parser
// Per-character phase machine, digit accumulator and field capture.
// Hands the captured fields over on the final character and restarts.
// ----------------------------------------------------------------------------
module itp_parser (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic [7:0]             text_char,
    input  logic                   is_final,
    output itp_pkg::fields_t       snap
);
    import itp_pkg::*;

    localparam logic [NUM_BITS-1:0] ACC_LIM = {NUM_BITS{1'b1}};
    localparam logic [POS_W-1:0]    POS_MAX = {POS_W{1'b1}};

    phase_t                phase_reg, phase_next, f_phase, e_phase;
    logic [NUM_BITS-1:0]   acc_reg, acc_next, f_acc;
    logic [POS_W-1:0]      pos_reg, pos_next, f_pos;
    logic [UNITS_W-1:0]    units_reg, units_next, f_units;
    logic [NUM_BITS-1:0]   day_reg, day_next, f_day;
    logic [NUM_BITS-1:0]   hour_reg, hour_next, f_hour;
    logic [NUM_BITS-1:0]   min_reg, min_next, f_min;
    logic [NUM_BITS-1:0]   sec_reg, sec_next, f_sec;
    logic [YEAR_W-1:0]     year_reg, year_next, f_year;
    logic [MONTH_W-1:0]    month_reg, month_next, f_month;
    logic                  fail_reg, fail_next, f_fail, e_fail;

    logic                  is_dig;
    logic [3:0]            dval;
    logic [NUM_BITS+3:0]   push_wide;
    logic                  push_sat;
    logic [NUM_BITS-1:0]   acc_push;
    logic [POS_W-1:0]      pos_push;
    logic                  fld_done;
    logic                  do_field;

    function automatic phase_t end_phase(input phase_t ph);
        phase_t r;
        case (ph)
            PH_DONE_DUR:  r = PH_DONE_DUR;
            PH_DONE_DATE: r = PH_DONE_DATE;
            PH_DUR:       r = PH_DONE_DUR;
            default:      r = PH_DONE_DATE;
        endcase
        return r;
    endfunction

    function automatic logic end_fail(input phase_t ph, input logic [POS_W-1:0] pos,
                                      input logic fl);
        logic r;
        case (ph)
            PH_DONE_DUR, PH_DONE_DATE:                  r = fl;
            PH_DUR:                                     r = fl | (pos != '0);
            PH_AFTER_DATE, PH_AFTER_MIN, PH_AFTER_COLON,
            PH_AFTER_SEC, PH_ZONE:                      r = fl;
            default:                                    r = 1'b1;
        endcase
        return r;
    endfunction

    assign is_dig    = text_char inside {[CH_0:CH_9]};
    assign dval      = 4'(text_char - CH_0);
    assign push_wide = (NUM_BITS + 4)'(acc_reg) * (NUM_BITS + 4)'(10) + (NUM_BITS + 4)'(dval);
    assign push_sat  = push_wide > (NUM_BITS + 4)'(ACC_LIM);
    assign acc_push  = push_sat ? ACC_LIM : push_wide[NUM_BITS-1:0];
    assign pos_push  = (pos_reg == POS_MAX) ? POS_MAX : pos_reg + POS_W'(1);
    assign fld_done  = (phase_reg == PH_YEAR) ? (pos_push >= POS_W'(4))
                                              : (pos_push >= POS_W'(2));

    always_comb
    begin
        f_phase  = phase_reg;
        f_acc    = acc_reg;
        f_pos    = pos_reg;
        f_units  = units_reg;
        f_day    = day_reg;
        f_hour   = hour_reg;
        f_min    = min_reg;
        f_sec    = sec_reg;
        f_year   = year_reg;
        f_month  = month_reg;
        f_fail   = fail_reg;
        do_field = 1'b0;
        if (!(phase_reg == PH_DONE_DUR || phase_reg == PH_DONE_DATE))
        begin
            if (text_char == CH_NUL)
            begin
                f_phase = end_phase(phase_reg);
                f_fail  = end_fail(phase_reg, pos_reg, fail_reg);
            end
            else if (!fail_reg)
            begin
                case (phase_reg)
                    PH_START:
                    begin
                        if (text_char == CH_P)
                            f_phase = PH_DUR;
                        else
                        begin
                            f_phase = PH_YEAR;
                            if (is_dig)
                            begin
                                f_acc  = acc_push;
                                f_pos  = pos_push;
                                f_fail = push_sat;
                            end
                            else
                                f_fail = 1'b1;
                        end
                    end
                    PH_DUR:
                    begin
                        if (is_dig)
                        begin
                            f_acc  = acc_push;
                            f_pos  = pos_push;
                            f_fail = push_sat;
                        end
                        else
                        begin
                            case (text_char)
                                CH_D:
                                begin
                                    if ((units_reg & MASK_D) != '0)
                                        f_fail = 1'b1;
                                    else
                                    begin
                                        f_units = units_reg | UNIT_D;
                                        f_day   = acc_reg;
                                        f_acc   = '0;
                                        f_pos   = '0;
                                    end
                                end
                                CH_H:
                                begin
                                    if ((units_reg & MASK_H) != '0)
                                        f_fail = 1'b1;
                                    else
                                    begin
                                        f_units = units_reg | UNIT_H;
                                        f_hour  = acc_reg;
                                        f_acc   = '0;
                                        f_pos   = '0;
                                    end
                                end
                                CH_M:
                                begin
                                    if ((units_reg & MASK_M) != '0)
                                        f_fail = 1'b1;
                                    else
                                    begin
                                        f_units = units_reg | UNIT_M;
                                        f_min   = acc_reg;
                                        f_acc   = '0;
                                        f_pos   = '0;
                                    end
                                end
                                CH_S:
                                begin
                                    if ((units_reg & MASK_S) != '0)
                                        f_fail = 1'b1;
                                    else
                                    begin
                                        f_units = units_reg | UNIT_S;
                                        f_sec   = acc_reg;
                                        f_acc   = '0;
                                        f_pos   = '0;
                                    end
                                end
                                default: f_fail = 1'b1;
                            endcase
                        end
                    end
                    PH_YEAR, PH_MONTH, PH_MONTH_X, PH_DAY, PH_HOUR, PH_MIN, PH_SEC:
                        do_field = 1'b1;
                    PH_AFTER_YEAR:
                    begin
                        if (text_char == CH_DASH)
                            f_phase = PH_MONTH_X;
                        else
                        begin
                            f_phase  = PH_MONTH;
                            do_field = 1'b1;
                        end
                    end
                    PH_AFTER_MONTH:
                    begin
                        f_phase  = PH_DAY;
                        do_field = 1'b1;
                    end
                    PH_AFTER_MONTH_X:
                    begin
                        if (text_char == CH_DASH)
                            f_phase = PH_DAY;
                        else
                            f_fail = 1'b1;
                    end
                    PH_AFTER_DATE:
                    begin
                        if (text_char == CH_T)
                            f_phase = PH_HOUR;
                        else
                            f_fail = 1'b1;
                    end
                    PH_AFTER_HOUR:
                    begin
                        f_phase  = PH_MIN;
                        do_field = (text_char != CH_COLON);
                    end
                    PH_AFTER_MIN:
                    begin
                        if (text_char == CH_COLON)
                            f_phase = PH_AFTER_COLON;
                        else if (text_char == CH_Z)
                            f_phase = PH_ZONE;
                        else
                        begin
                            f_phase  = PH_SEC;
                            do_field = 1'b1;
                        end
                    end
                    PH_AFTER_COLON:
                    begin
                        f_phase  = PH_SEC;
                        do_field = 1'b1;
                    end
                    PH_AFTER_SEC:
                    begin
                        if (text_char == CH_Z)
                            f_phase = PH_ZONE;
                        else
                            f_fail = 1'b1;
                    end
                    PH_ZONE: f_fail = 1'b1;
                    default: ;
                endcase

                if (do_field)
                begin
                    if (!is_dig)
                        f_fail = 1'b1;
                    else
                    begin
                        f_acc  = acc_push;
                        f_pos  = fld_done ? '0 : pos_push;
                        f_fail = push_sat;
                    end
                end

                // completed fixed-width field: take the accumulator
                if (do_field && is_dig && fld_done)
                begin
                    case (phase_reg)
                        PH_YEAR:
                        begin
                            f_year  = acc_push[YEAR_W-1:0];
                            f_acc   = '0;
                            f_phase = PH_AFTER_YEAR;
                        end
                        PH_MONTH:
                        begin
                            f_month = acc_push[MONTH_W-1:0];
                            f_acc   = '0;
                            f_phase = PH_AFTER_MONTH;
                        end
                        PH_MONTH_X:
                        begin
                            f_month = acc_push[MONTH_W-1:0];
                            f_acc   = '0;
                            f_phase = PH_AFTER_MONTH_X;
                        end
                        PH_DAY:
                        begin
                            f_day   = acc_push;
                            f_acc   = '0;
                            f_phase = PH_AFTER_DATE;
                        end
                        PH_HOUR:
                        begin
                            f_hour  = acc_push;
                            f_acc   = '0;
                            f_phase = PH_AFTER_HOUR;
                        end
                        PH_MIN:
                        begin
                            f_min   = acc_push;
                            f_acc   = '0;
                            f_phase = PH_AFTER_MIN;
                        end
                        PH_SEC:
                        begin
                            f_sec   = acc_push;
                            f_acc   = '0;
                            f_phase = PH_AFTER_SEC;
                        end
                        default: ;
                    endcase
                end
            end
        end
    end

    assign e_phase = end_phase(f_phase);
    assign e_fail  = end_fail(f_phase, f_pos, f_fail);

    always_comb
    begin
        snap.kind   = (e_phase != PH_DONE_DUR);
        snap.failed = e_fail;
        snap.year   = f_year;
        snap.month  = f_month;
        snap.day    = f_day;
        snap.hour   = f_hour;
        snap.minute = f_min;
        snap.second = f_sec;
    end

    always_comb
    begin
        if (is_final)
        begin
            phase_next = PH_START;
            acc_next   = '0;
            pos_next   = '0;
            units_next = '0;
            day_next   = '0;
            hour_next  = '0;
            min_next   = '0;
            sec_next   = '0;
            year_next  = '0;
            month_next = '0;
            fail_next  = 1'b0;
        end
        else
        begin
            phase_next = f_phase;
            acc_next   = f_acc;
            pos_next   = f_pos;
            units_next = f_units;
            day_next   = f_day;
            hour_next  = f_hour;
            min_next   = f_min;
            sec_next   = f_sec;
            year_next  = f_year;
            month_next = f_month;
            fail_next  = f_fail;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            acc_reg   <= '0;
            pos_reg   <= '0;
            units_reg <= '0;
            day_reg   <= '0;
            hour_reg  <= '0;
            min_reg   <= '0;
            sec_reg   <= '0;
            year_reg  <= '0;
            month_reg <= '0;
            fail_reg  <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            pos_reg   <= pos_next;
            units_reg <= units_next;
            day_reg   <= day_next;
            hour_reg  <= hour_next;
            min_reg   <= min_next;
            sec_reg   <= sec_next;
            year_reg  <= year_next;
            month_reg <= month_next;
            fail_reg  <= fail_next;
        end
    end

endmodule

// File: sv/itp_convert.sv
// ----------------------------------------------------------------------------
// itp_convert: seconds conversion pipeline
// Civil date to day count, seconds sum with duration limit check, and the
// output register. The whole pipeline advances together.
// ----------------------------------------------------------------------------
module itp_convert (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        fire,
    input  itp_pkg::fields_t            snap,
    output logic                        ready,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [itp_pkg::TIME_W-1:0]  out_time,
    output logic                        out_kind,
    output logic                        out_error
);
    import itp_pkg::*;

    localparam int STAGES = 8;
    localparam int MQ_MAX = (2 ** MONTH_W - 1) / MONTHS_PER_YEAR;
    localparam logic [SUM_W-1:0] TIME_LIMIT = SUM_W'({LIMIT_W{1'b1}});

    logic                 adv;
    logic [STAGES-1:0]    vld_reg;
    logic                 out_valid_reg;

    fields_t s1_reg, s2_reg, s3_reg, s4_reg, s5_reg, s6_reg, s7_reg;

    logic [YADJ_W-1:0]    yadj_next, yadj2_reg, yadj3_reg;
    logic [MI_W-1:0]      mp_next, mp2_reg, mp3_reg, mp4_reg;
    logic [ERA_PROD_W-1:0] era_prod;
    logic [ERA_W-1:0]     era_next, era3_reg, era4_reg;
    logic [YOE_W-1:0]     yoe_next, yoe4_reg;
    logic [DOE_W-1:0]     doe_next, doe5_reg;
    logic [ERA_DAYS_W-1:0] era_days_next, era_days5_reg;
    logic signed [DAYS_W-1:0] days_next, days6_reg;
    logic signed [DMUL_W-1:0] dmul;
    logic signed [SUM_W-1:0]  p_day_next, p_day_reg;
    logic [SUM_W-1:0]     p_hour_next, p_hour_reg;
    logic [SUM_W-1:0]     p_min_next, p_min_reg;
    logic [SUM_W-1:0]     p_sec_next, p_sec_reg;
    logic signed [SUM_W-1:0]  total_next, total_reg;
    logic                 kind8_reg, fail8_reg;

    logic [MONTH_W-1:0]   mo_m1;
    logic [3:0]           mq;
    logic [MI_W-1:0]      mi;
    logic                 ydec;
    logic [1:0]           q100;

    logic [TIME_W-1:0]    time_next, time_reg;
    logic                 kind_reg, err_next, err_reg;

    assign adv   = !out_valid_reg || out_ready;
    assign ready = adv;

    // month roll-over: year carry and March-based month index
    assign mo_m1 = s1_reg.month - MONTH_W'(1);
    always_comb
    begin
        mq = '0;
        for (int k = 1; k <= MQ_MAX; k++)
        begin
            if (mo_m1 >= MONTH_W'(MONTHS_PER_YEAR * k))
                mq = mq + 4'd1;
        end
        if (s1_reg.month == '0)
        begin
            mq = '0;
            mi = MI_W'(MONTHS_PER_YEAR - 1);
        end
        else
            mi = MI_W'(mo_m1 - MONTH_W'(MONTHS_PER_YEAR) * MONTH_W'(mq));
        ydec      = (s1_reg.month == '0) || (mi <= MI_W'(1));
        yadj_next = YADJ_W'(s1_reg.year) + YADJ_W'(mq) + YADJ_W'(YEARS_PER_ERA)
                  - YADJ_W'(ydec);
        mp_next   = (mi >= MI_W'(2)) ? mi - MI_W'(2) : mi + MI_W'(10);
    end

    assign era_prod = ERA_PROD_W'(yadj2_reg) * ERA_PROD_W'(ERA_RECIP);
    assign era_next = era_prod[ERA_SHIFT +: ERA_W];

    assign yoe_next = YOE_W'(yadj3_reg - YADJ_W'(era3_reg) * YADJ_W'(YEARS_PER_ERA));

    always_comb
    begin
        if (yoe4_reg >= YOE_W'(300))
            q100 = 2'd3;
        else if (yoe4_reg >= YOE_W'(200))
            q100 = 2'd2;
        else if (yoe4_reg >= YOE_W'(100))
            q100 = 2'd1;
        else
            q100 = 2'd0;
        doe_next = DOE_W'(yoe4_reg) * DOE_W'(DAYS_PER_YEAR) + DOE_W'(yoe4_reg >> 2)
                 - DOE_W'(q100) + DOE_W'(month_offset(mp4_reg));
        era_days_next = ERA_DAYS_W'(era4_reg) * ERA_DAYS_W'(DAYS_PER_ERA);
    end

    assign days_next = DAYS_W'(era_days5_reg) + DAYS_W'(doe5_reg)
                     + DAYS_W'(s5_reg.day[DATE_FIELD_W-1:0]) - DAYS_W'(EPOCH_DAY_OFFSET);

    always_comb
    begin
        if (s6_reg.kind)
            dmul = DMUL_W'(days6_reg);
        else
            dmul = $signed(DMUL_W'(s6_reg.day));
        p_day_next  = SUM_W'(dmul) * $signed(SUM_W'(SEC_PER_DAY));
        p_hour_next = SUM_W'(s6_reg.hour) * SUM_W'(SEC_PER_HOUR);
        p_min_next  = SUM_W'(s6_reg.minute) * SUM_W'(SEC_PER_MIN);
        p_sec_next  = SUM_W'(s6_reg.second);
    end

    assign total_next = p_day_reg + $signed(p_hour_reg) + $signed(p_min_reg)
                      + $signed(p_sec_reg);

    always_comb
    begin
        err_next  = fail8_reg;
        time_next = '0;
        if (!fail8_reg)
        begin
            if (!kind8_reg)
            begin
                if (total_reg > $signed(TIME_LIMIT))
                    err_next = 1'b1;
                else
                    time_next = total_reg[TIME_W-1:0];
            end
            else if (total_reg < 0)
                time_next = '1;
            else
                time_next = total_reg[TIME_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg       <= {vld_reg[STAGES-2:0], fire};
            out_valid_reg <= vld_reg[STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg        <= snap;
            s2_reg        <= s1_reg;
            yadj2_reg     <= yadj_next;
            mp2_reg       <= mp_next;
            s3_reg        <= s2_reg;
            yadj3_reg     <= yadj2_reg;
            mp3_reg       <= mp2_reg;
            era3_reg      <= era_next;
            s4_reg        <= s3_reg;
            mp4_reg       <= mp3_reg;
            era4_reg      <= era3_reg;
            yoe4_reg      <= yoe_next;
            s5_reg        <= s4_reg;
            doe5_reg      <= doe_next;
            era_days5_reg <= era_days_next;
            s6_reg        <= s5_reg;
            days6_reg     <= days_next;
            s7_reg        <= s6_reg;
            p_day_reg     <= p_day_next;
            p_hour_reg    <= p_hour_next;
            p_min_reg     <= p_min_next;
            p_sec_reg     <= p_sec_next;
            kind8_reg     <= s7_reg.kind;
            fail8_reg     <= s7_reg.failed;
            total_reg     <= total_next;
            time_reg      <= time_next;
            kind_reg      <= kind8_reg;
            err_reg       <= err_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_time  = time_reg;
    assign out_kind  = kind_reg;
    assign out_error = err_reg;

endmodule

// File: sv/iso8601_time_parser.sv
// ----------------------------------------------------------------------------
// iso8601_time_parser: ISO 8601 duration and date-time parser
// Streams one text character per input beat; the beat with s_tlast high
// ends the string and yields one result beat on the master side.
//
// s_tdata carries the character, s_tlast marks the end of the string (a NUL
// character on that beat is not part of the text). m_tdata carries the time
// in seconds (duration, or UTC epoch seconds; 0 on error, -1 before the
// epoch). m_tuser carries the kind and the error flag.
// Throughput: one character beat per cycle, unless a final character waits
// for a held pipeline. A result beat passes through one input register,
// then an eight-stage conversion pipeline (year/era division by reciprocal,
// day count, seconds products, sum) and the output register.
// Reset clears the parser state and empties the pipeline. While a result
// beat waits with m_tready low the conversion pipeline holds; non-final
// characters are still taken, a final character waits in the input register
// until the pipeline moves.
// ----------------------------------------------------------------------------
module iso8601_time_parser (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [itp_pkg::IN_TDATA_W-1:0]    s_tdata,   // [7:0] text_char
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [itp_pkg::OUT_TDATA_W-1:0]   m_tdata,   // [48:0] time_seconds
    output logic [itp_pkg::OUT_TUSER_W-1:0]   m_tuser    // [0] value_kind, [1] parse_error
);
    import itp_pkg::*;

    logic                   in_valid_reg;
    logic [IN_TDATA_W-1:0]  in_char_reg;
    logic                   in_last_reg;
    logic                   conv_ready;
    logic                   step;
    logic                   fire;
    fields_t                snap;
    logic [TIME_W-1:0]      res_time;
    logic                   res_kind;
    logic                   res_error;

    assign step     = in_valid_reg && (!in_last_reg || conv_ready);
    assign fire     = step && in_last_reg;
    assign s_tready = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    itp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .text_char (in_char_reg),
        .is_final  (in_last_reg),
        .snap      (snap)
    );

    itp_convert u_convert (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .snap      (snap),
        .ready     (conv_ready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_time  (res_time),
        .out_kind  (res_kind),
        .out_error (res_error)
    );

    assign m_tdata = OUT_TDATA_W'(res_time);
    assign m_tuser = {res_error, res_kind};

endmodule

// File: test/iso8601_time_parser_tb.sv
// ----------------------------------------------------------------------------
// iso8601_time_parser_tb: self-checking bench for the ISO 8601 time parser
// Streams duration and date-time strings one character beat at a time, runs
// the same text through a behavioral parser, and checks every result beat
// against it or against a value typed into the table. A short table of
// hand-picked strings comes first, then generated text, mostly well formed
// with some damaged strings and noise, under four sender/receiver idle patterns.
// ----------------------------------------------------------------------------
module iso8601_time_parser_tb;

    import itp_pkg::*;

    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          RANDOM_BEATS   = 900;
    localparam int          DRAIN_CYCLES   = 30;
    localparam logic [63:0] ACC_MAX        = (64'd1 << NUM_BITS) - 64'd1;
    localparam logic [63:0] TIME_MAX       = (64'd1 << LIMIT_W) - 64'd1;

    typedef struct packed {
        logic [TIME_W-1:0] secs;
        logic              kind;
        logic              err;
    } parse_result_t;

    // one directed string: body chars, optional NUL before index nul_at, final char
    typedef struct {
        string             body;
        int                nul_at;
        logic [7:0]        tail;
        bit                typed;
        logic [TIME_W-1:0] secs;
        logic              kind;
        logic              err;
    } dir_row_t;

    localparam int DIR_ROWS = 10;

    dir_row_t dir_rows [DIR_ROWS] = '{
        '{"",              -1, CH_NUL,        1'b1, '0,             1'b1, 1'b1},
        '{"",              -1, CH_P,          1'b1, '0,             1'b0, 1'b0},
        '{"P",             -1, CH_0 + 8'd5,   1'b1, '0,             1'b0, 1'b1},
        '{"PM",            -1, CH_H,          1'b1, '0,             1'b0, 1'b1},
        '{"P9999999999",   -1, CH_S,          1'b1, '0,             1'b0, 1'b1},
        '{"1970010",       -1, CH_0 + 8'd1,   1'b1, '0,             1'b1, 1'b0},
        '{"1969123",       -1, CH_0 + 8'd1,   1'b1, {TIME_W{1'b1}}, 1'b1, 1'b0},
        '{"",              -1, 8'hFF,         1'b1, '0,             1'b1, 1'b1},
        '{"P3DQ",           3, CH_S,          1'b0, '0,             1'b0, 1'b0},
        '{"20001300T2561", -1, CH_Z,          1'b0, '0,             1'b0, 1'b0}
    };

    int gap_by_phase   [4] = '{0, 67, 0, 31};
    int stall_by_phase [4] = '{0, 0, 67, 31};

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   s_tlast  = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [OUT_TUSER_W-1:0] m_tuser;

    // parser shadow state
    phase_t             cur_phase;
    logic [63:0]        acc_num;
    logic [3:0]         acc_digits;
    logic [UNITS_W-1:0] units_used;
    logic [63:0]        f_day, f_hour, f_min, f_sec, f_year, f_month;
    logic               txt_failed;

    parse_result_t expected_times [$];
    parse_result_t typed_res;
    bit            typed_pending = 1'b0;
    logic [7:0]    text_buf [$];

    int send_gap_pct    = 0;
    int stall_pct       = 0;
    int mismatches      = 0;
    int beats_sent      = 0;
    int strings_sent    = 0;
    int results_checked = 0;
    int durations_seen  = 0;
    int flagged_seen    = 0;
    int idle_cycles     = 0;

    iso8601_time_parser u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // [7:0] text_char
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // [48:0] time_seconds
        .m_tuser  (m_tuser)     // [0] value_kind, [1] parse_error
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic void clear_parser();
        cur_phase  = PH_START;
        acc_num    = '0;
        acc_digits = '0;
        units_used = '0;
        f_day      = '0;
        f_hour     = '0;
        f_min      = '0;
        f_sec      = '0;
        f_year     = '0;
        f_month    = '0;
        txt_failed = 1'b0;
    endfunction

    function automatic bit is_num(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic void take_digit(input logic [7:0] c);
        logic [63:0] v;
        v = acc_num * 64'd10 + 64'(c - CH_0);
        if (v > ACC_MAX)
        begin
            v = ACC_MAX;
            txt_failed = 1'b1;
        end
        acc_num = v;
        if (acc_digits < 4'd15)
            acc_digits++;
    endfunction

    function automatic logic [63:0] pop_number();
        logic [63:0] v;
        v = acc_num;
        acc_num = '0;
        acc_digits = '0;
        return v;
    endfunction

    // true once a fixed-width date/time field has all its digits
    function automatic bit field_char(input logic [7:0] c, input int width);
        if (!is_num(c))
        begin
            txt_failed = 1'b1;
            return 1'b0;
        end
        take_digit(c);
        if (acc_digits >= width)
        begin
            acc_digits = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // units must come in falling order, each once
    function automatic void take_unit(input logic [7:0] c);
        logic [UNITS_W-1:0] mask;
        logic [UNITS_W-1:0] flag;
        case (c)
            CH_D:
            begin
                mask = MASK_D;
                flag = UNIT_D;
            end
            CH_H:
            begin
                mask = MASK_H;
                flag = UNIT_H;
            end
            CH_M:
            begin
                mask = MASK_M;
                flag = UNIT_M;
            end
            CH_S:
            begin
                mask = MASK_S;
                flag = UNIT_S;
            end
            default:
            begin
                txt_failed = 1'b1;
                return;
            end
        endcase
        if ((units_used & mask) != '0)
        begin
            txt_failed = 1'b1;
            return;
        end
        units_used |= flag;
        case (c)
            CH_D:    f_day  = pop_number();
            CH_H:    f_hour = pop_number();
            CH_M:    f_min  = pop_number();
            default: f_sec  = pop_number();
        endcase
    endfunction

    function automatic void parse_char(input logic [7:0] c);
        case (cur_phase)
            PH_START:
                if (c == CH_P)
                    cur_phase = PH_DUR;
                else
                begin
                    cur_phase = PH_YEAR;
                    if (is_num(c))
                        take_digit(c);
                    else
                        txt_failed = 1'b1;
                end
            PH_DUR:
                if (is_num(c))
                    take_digit(c);
                else
                    take_unit(c);
            PH_YEAR:
                if (field_char(c, 4))
                begin
                    f_year = pop_number();
                    cur_phase = PH_AFTER_YEAR;
                end
            PH_AFTER_YEAR:
                if (c == CH_DASH)
                    cur_phase = PH_MONTH_X;
                else
                begin
                    cur_phase = PH_MONTH;
                    void'(field_char(c, 2));
                end
            PH_MONTH, PH_MONTH_X:
                if (field_char(c, 2))
                begin
                    f_month = pop_number();
                    cur_phase = (cur_phase == PH_MONTH) ? PH_AFTER_MONTH : PH_AFTER_MONTH_X;
                end
            PH_AFTER_MONTH:
            begin
                cur_phase = PH_DAY;
                void'(field_char(c, 2));
            end
            PH_AFTER_MONTH_X:
                if (c == CH_DASH)
                    cur_phase = PH_DAY;
                else
                    txt_failed = 1'b1;
            PH_DAY:
                if (field_char(c, 2))
                begin
                    f_day = pop_number();
                    cur_phase = PH_AFTER_DATE;
                end
            PH_AFTER_DATE:
                if (c == CH_T)
                    cur_phase = PH_HOUR;
                else
                    txt_failed = 1'b1;
            PH_HOUR:
                if (field_char(c, 2))
                begin
                    f_hour = pop_number();
                    cur_phase = PH_AFTER_HOUR;
                end
            PH_AFTER_HOUR:
            begin
                cur_phase = PH_MIN;
                if (c != CH_COLON)
                    void'(field_char(c, 2));
            end
            PH_MIN:
                if (field_char(c, 2))
                begin
                    f_min = pop_number();
                    cur_phase = PH_AFTER_MIN;
                end
            PH_AFTER_MIN:
                if (c == CH_COLON)
                    cur_phase = PH_AFTER_COLON;
                else if (c == CH_Z)
                    cur_phase = PH_ZONE;
                else
                begin
                    cur_phase = PH_SEC;
                    void'(field_char(c, 2));
                end
            PH_AFTER_COLON:
            begin
                cur_phase = PH_SEC;
                void'(field_char(c, 2));
            end
            PH_SEC:
                if (field_char(c, 2))
                begin
                    f_sec = pop_number();
                    cur_phase = PH_AFTER_SEC;
                end
            PH_AFTER_SEC:
                if (c == CH_Z)
                    cur_phase = PH_ZONE;
                else
                    txt_failed = 1'b1;
            PH_ZONE:
                txt_failed = 1'b1;
            default:
                ;
        endcase
    endfunction

    function automatic void close_text();
        if (cur_phase == PH_DONE_DUR || cur_phase == PH_DONE_DATE)
            return;
        if (cur_phase == PH_DUR)
        begin
            if (acc_digits != '0)
                txt_failed = 1'b1;
            cur_phase = PH_DONE_DUR;
            return;
        end
        if (!(cur_phase inside {PH_AFTER_DATE, PH_AFTER_MIN, PH_AFTER_COLON,
                                PH_AFTER_SEC, PH_ZONE}))
            txt_failed = 1'b1;
        cur_phase = PH_DONE_DATE;
    endfunction

    // days-from-civil on a March-based year, fields rolled over first
    function automatic longint epoch_seconds();
        longint y, mi, mo, era, yoe, mp, doe, days, total;
        y  = longint'(f_year);
        mi = longint'(f_month) - 1;
        if (mi < 0)
        begin
            y  -= 1;
            mi += MONTHS_PER_YEAR;
        end
        y  += mi / MONTHS_PER_YEAR;
        mi  = mi % MONTHS_PER_YEAR;
        mo  = mi + 1;
        y  += YEARS_PER_ERA;
        if (mo <= 2)
            y -= 1;
        era  = y / YEARS_PER_ERA;
        yoe  = y - era * YEARS_PER_ERA;
        mp   = (mo > 2) ? mo - 3 : mo + 9;
        doe  = yoe * DAYS_PER_YEAR + yoe / 4 - yoe / 100 + (153 * mp + 2) / 5;
        days = era * DAYS_PER_ERA + doe - 719468 - DAYS_PER_ERA + (longint'(f_day) - 1);
        total = days * SEC_PER_DAY + longint'(f_hour) * SEC_PER_HOUR
              + longint'(f_min) * SEC_PER_MIN + longint'(f_sec);
        return (total < 0) ? -64'sd1 : total;
    endfunction

    function automatic void step_parser(input logic [7:0] c, input logic fin,
                                        output parse_result_t res);
        logic [63:0] total_dur;
        longint      stamp;
        res = '0;
        if (cur_phase != PH_DONE_DUR && cur_phase != PH_DONE_DATE)
        begin
            if (c == CH_NUL)
                close_text();
            else if (!txt_failed)
                parse_char(c);
        end
        if (fin)
        begin
            close_text();
            res.kind = (cur_phase != PH_DONE_DUR);
            if (!txt_failed)
            begin
                if (cur_phase == PH_DONE_DUR)
                begin
                    // terms are non-negative, so checking the full sum matches
                    // checking each partial sum
                    total_dur = f_sec + f_min * SEC_PER_MIN + f_hour * SEC_PER_HOUR
                              + f_day * SEC_PER_DAY;
                    if (total_dur > TIME_MAX)
                        txt_failed = 1'b1;
                    else
                        res.secs = total_dur[TIME_W-1:0];
                end
                else
                begin
                    stamp = epoch_seconds();
                    res.secs = stamp[TIME_W-1:0];
                end
            end
            res.err = txt_failed;
            clear_parser();
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        $display("mismatch @%0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
    endtask

    task automatic send_beat(input logic [7:0] ch, input logic fin);
        parse_result_t res;
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= fin;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        step_parser(ch, fin, res);
        if (fin)
        begin
            expected_times.insert(expected_times.size(), typed_pending ? typed_res : res);
            typed_pending = 1'b0;
            strings_sent++;
        end
        beats_sent++;
    endtask

    function automatic void add_char(input logic [7:0] c);
        text_buf.insert(text_buf.size(), c);
    endfunction

    task automatic put_value(input int unsigned v, input int width);
        int unsigned div;
        div = 1;
        repeat (width - 1)
            div *= 10;
        repeat (width)
        begin
            add_char(CH_0 + 8'((v / div) % 10));
            div /= 10;
        end
    endtask

    task automatic put_digits(input int n);
        repeat (n)
            add_char(CH_0 + 8'($urandom_range(0, 9)));
    endtask

    always @(posedge clk)
        m_tready <= ($urandom_range(0, 99) >= stall_pct);

    always @(posedge clk)
    begin : check_results
        parse_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_checked++;
            if (expected_times.size() == 0)
                report_mismatch("result beat with nothing pending", 64'(m_tdata), 64'd0);
            else
            begin
                want = expected_times.pop_front();
                if (!want.kind)
                    durations_seen++;
                if (want.err)
                    flagged_seen++;
                if (m_tdata[TIME_W-1:0] !== want.secs)
                    report_mismatch("time_seconds", 64'(m_tdata[TIME_W-1:0]), 64'(want.secs));
                if (m_tuser[0] !== want.kind)
                    report_mismatch("value_kind", 64'(m_tuser[0]), 64'(want.kind));
                if (m_tuser[1] !== want.err)
                    report_mismatch("parse_error", 64'(m_tuser[1]), 64'(want.err));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no beat moved for %0d cycles", idle_cycles);
            $display("FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : stimulus
        int  phase_end;
        int  shape;
        int  pos;
        int  tail_kind;
        bit  dashed;
        bit  nul_end;
        clear_parser();
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[r])
        begin
            for (int i = 0; i < dir_rows[r].body.len(); i++)
            begin
                if (i == dir_rows[r].nul_at)
                    send_beat(CH_NUL, 1'b0);
                send_beat(dir_rows[r].body[i], 1'b0);
            end
            typed_pending = dir_rows[r].typed;
            typed_res = '{secs: dir_rows[r].secs, kind: dir_rows[r].kind,
                          err: dir_rows[r].err};
            send_beat(dir_rows[r].tail, 1'b1);
        end

        for (int p = 0; p < 4; p++)
        begin
            // hold off until every pending result has drained
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while (expected_times.size() != 0);
            send_gap_pct = gap_by_phase[p];
            stall_pct    = stall_by_phase[p];
            phase_end    = beats_sent + RANDOM_BEATS / 4;
            while (beats_sent < phase_end)
            begin
                text_buf.delete();
                shape = $urandom_range(0, 99);
                if (shape < 45)
                begin
                    dashed = $urandom_range(0, 1);
                    put_value(($urandom_range(0, 7) == 0) ? $urandom_range(0, 9999)
                                                          : $urandom_range(1900, 2100), 4);
                    if (dashed)
                        add_char(CH_DASH);
                    put_value(($urandom_range(0, 5) == 0) ? $urandom_range(0, 99)
                                                          : $urandom_range(1, 12), 2);
                    if (dashed)
                        add_char(CH_DASH);
                    put_value(($urandom_range(0, 5) == 0) ? $urandom_range(0, 99)
                                                          : $urandom_range(1, 28), 2);
                    if ($urandom_range(0, 3) != 0)
                    begin
                        add_char(CH_T);
                        put_value(($urandom_range(0, 5) == 0) ? $urandom_range(0, 99)
                                                              : $urandom_range(0, 23), 2);
                        if ($urandom_range(0, 1))
                            add_char(CH_COLON);
                        put_value(($urandom_range(0, 5) == 0) ? $urandom_range(0, 99)
                                                              : $urandom_range(0, 59), 2);
                        tail_kind = $urandom_range(0, 3);
                        if (tail_kind == 1)
                            add_char(CH_COLON);
                        else if (tail_kind >= 2)
                        begin
                            if ($urandom_range(0, 1))
                                add_char(CH_COLON);
                            put_value(($urandom_range(0, 5) == 0) ? $urandom_range(0, 99)
                                                                  : $urandom_range(0, 59), 2);
                        end
                        if ($urandom_range(0, 1))
                            add_char(CH_Z);
                    end
                    else if ($urandom_range(0, 7) == 0)
                        add_char(CH_Z);
                end
                else if (shape < 80)
                begin
                    add_char(CH_P);
                    for (int u = 0; u < 4; u++)
                    begin
                        if ($urandom_range(0, 2) != 0)
                        begin
                            case ($urandom_range(0, 19))
                                0:       put_value($urandom(), 10);
                                1:       put_digits(11);
                                default: put_digits($urandom_range(0, 3));
                            endcase
                            case (u)
                                0:       add_char(CH_D);
                                1:       add_char(CH_H);
                                2:       add_char(CH_M);
                                default: add_char(CH_S);
                            endcase
                        end
                    end
                    if ($urandom_range(0, 9) == 0)
                        put_digits($urandom_range(1, 2));
                end
                else
                begin
                    repeat ($urandom_range(0, 5))
                        add_char(8'($urandom_range(0, 255)));
                end

                // damage some well-formed strings
                if (shape < 80 && $urandom_range(0, 99) < 20)
                begin
                    pos = $urandom_range(0, text_buf.size() - 1);
                    case ($urandom_range(0, 4))
                        0:       text_buf[pos] = 8'($urandom_range(0, 255));
                        1:       text_buf.delete(pos);
                        2:       text_buf.insert(pos, CH_NUL);
                        3:       add_char($urandom_range(0, 1) ? CH_Z
                                          : 8'($urandom_range(0, 255)));
                        default:
                            while (text_buf.size() > pos)
                                void'(text_buf.pop_back());
                    endcase
                end

                nul_end = (text_buf.size() == 0) || ($urandom_range(0, 4) == 0);
                foreach (text_buf[i])
                    send_beat(text_buf[i], !nul_end && (i == text_buf.size() - 1));
                if (nul_end)
                    send_beat(CH_NUL, 1'b1);
            end
        end

        s_tvalid <= 1'b0;
        while (expected_times.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("sent %0d strings in %0d character beats over four idle patterns",
                 strings_sent, beats_sent);
        $display("checked %0d results: %0d durations, %0d flagged malformed, %0d mismatches",
                 results_checked, durations_seen, flagged_seen, mismatches);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: files.f
sv/itp_pkg.sv
sv/itp_parser.sv
sv/itp_convert.sv
sv/iso8601_time_parser.sv
test/iso8601_time_parser_tb.sv
